// ===== src/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic task timer table
// Input and result word layouts, command and result codes, time constants.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ONESHOT  = 2'd1;
  localparam logic [1:0] CMD_PERIODIC = 2'd2;
  localparam logic [1:0] CMD_TOD      = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // seconds of day; out-of-range time fields reach 115443, so 17 bits
  typedef logic [16:0] secs_t;

  localparam secs_t SEC_PER_DAY  = 17'd86400;
  localparam secs_t SEC_PER_HOUR = 17'd3600;
  localparam secs_t SEC_PER_MIN  = 17'd60;

  typedef logic signed [24:0] cdown_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_handle;
    logic [23:0] delay_seconds;
    logic [15:0] elapsed_seconds;
    logic [4:0]  target_hour;
    logic [5:0]  target_minute;
    logic [5:0]  target_second;
    logic [4:0]  wall_hour;
    logic [5:0]  wall_minute;
    logic [5:0]  wall_second;
    logic        daily;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fired_handle;
    logic        last;
  } out_word_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] handle;
    logic [23:0] period;
    cdown_t      countdown;
    logic [15:0] elapsed;
  } op_t;

  // one table entry
  typedef struct packed {
    logic [15:0] handle;
    logic [23:0] period;
    cdown_t      countdown;
  } entry_t;

endpackage

// ===== src/ptt_front.sv =====
// ----------------------------------------------------------------------------
// ptt_front: input stage
// Takes input words, converts times of day to seconds, builds table ops.
// ----------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     op_valid,
  input  logic     op_ready,
  output op_t      op_data
);

  function automatic secs_t day_secs(input logic [4:0] h, input logic [5:0] m,
                                     input logic [5:0] s);
    return secs_t'(secs_t'(h) * SEC_PER_HOUR) + secs_t'(secs_t'(m) * SEC_PER_MIN)
           + secs_t'(s);
  endfunction

  logic     hold_v_r, hold_v_nxt;
  in_word_t hold_r;
  secs_t    tgt_r, now_r;
  logic     in_fire, push;
  cdown_t   tod_cd;

  assign in_fire  = in_valid && in_ready;
  assign push     = hold_v_r && op_ready;
  assign in_ready = !hold_v_r || op_ready;
  assign op_valid = hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_fire) begin
      hold_v_nxt = 1'b1;
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r <= in_data;
      tgt_r  <= day_secs(in_data.target_hour, in_data.target_minute, in_data.target_second);
      now_r  <= day_secs(in_data.wall_hour, in_data.wall_minute, in_data.wall_second);
    end
  end

  // target before now rolls over to tomorrow
  assign tod_cd = $signed({8'd0, tgt_r})
                + ((tgt_r < now_r) ? $signed({8'd0, SEC_PER_DAY}) : 25'sd0)
                - $signed({8'd0, now_r});

  always_comb begin
    op_data.cmd     = hold_r.command;
    op_data.handle  = hold_r.task_handle;
    op_data.elapsed = hold_r.elapsed_seconds;
    unique case (hold_r.command)
      CMD_ONESHOT: begin
        op_data.period    = '0;
        op_data.countdown = $signed({1'b0, hold_r.delay_seconds});
      end
      CMD_PERIODIC: begin
        op_data.period    = hold_r.delay_seconds;
        op_data.countdown = $signed({1'b0, hold_r.delay_seconds});
      end
      CMD_TOD: begin
        op_data.period    = hold_r.daily ? 24'(SEC_PER_DAY) : '0;
        op_data.countdown = tod_cd;
      end
      default: begin
        op_data.period    = '0;
        op_data.countdown = '0;
      end
    endcase
  end

endmodule

// ===== src/ptt_queue.sv =====
// ----------------------------------------------------------------------------
// ptt_queue: two-entry op queue
// Decouples the input stage from the table walker.
// ----------------------------------------------------------------------------
module ptt_queue import ptt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  op_t        slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ptt_back.sv =====
// ----------------------------------------------------------------------------
// ptt_back: table walker
// Holds the timer table, performs adds and walks it one entry per cycle on tick unless results stall.
// ----------------------------------------------------------------------------
module ptt_back import ptt_pkg::*; #(
  parameter int MAX_TASKS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_t       op_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  entry_t mem [MAX_TASKS];

  logic [1:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [15:0]      elap_r, elap_nxt;
  entry_t           rd_ent_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;

  logic             rd_en, wr_en, emit, out_free, fired, advance;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_ent;
  out_word_t        emit_word;
  cdown_t           cd_sub;

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cd_sub = rd_ent_r.countdown - $signed({9'd0, elap_r});
  assign fired  = cd_sub[24] || (cd_sub == '0);

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    elap_nxt  = elap_r;
    op_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = i_r[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = i_r[IDX_W-1:0];
    wr_ent    = rd_ent_r;
    emit      = 1'b0;
    emit_word = '0;
    advance   = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (op_valid) begin
          if (op_data.cmd == CMD_TICK) begin
            op_ready = 1'b1;
            elap_nxt = op_data.elapsed;
            i_nxt    = '0;
            if (cnt_r == '0) begin
              st_nxt = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              st_nxt  = ST_EVAL;
            end
          end else if (out_free) begin
            op_ready               = 1'b1;
            emit                   = 1'b1;
            emit_word.fired_handle = op_data.handle;
            emit_word.last         = 1'b1;
            if (cnt_r == CNT_FULL) begin
              emit_word.kind = KIND_REJECTED;
            end else begin
              emit_word.kind   = KIND_ACCEPTED;
              wr_en            = 1'b1;
              wr_addr          = cnt_r[IDX_W-1:0];
              wr_ent.handle    = op_data.handle;
              wr_ent.period    = op_data.period;
              wr_ent.countdown = op_data.countdown;
              cnt_nxt          = cnt_r + 1'b1;
            end
          end
        end
      end
      ST_EVAL: begin
        if (!fired) begin
          advance          = 1'b1;
          wr_en            = 1'b1;
          wr_ent.countdown = cd_sub;
          i_nxt            = i_r + 1'b1;
        end else if (out_free) begin
          advance                = 1'b1;
          emit                   = 1'b1;
          emit_word.kind         = KIND_FIRED;
          emit_word.fired_handle = rd_ent_r.handle;
          if (rd_ent_r.period != '0) begin
            wr_en            = 1'b1;
            wr_ent.countdown = $signed({1'b0, rd_ent_r.period});
            i_nxt            = i_r + 1'b1;
          end else begin
            // one-shot gone: last entry moves here and is checked next
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        if (advance) begin
          if (i_nxt < cnt_nxt) begin
            rd_en   = 1'b1;
            rd_addr = (fired && rd_ent_r.period == '0) ? cnt_nxt[IDX_W-1:0]
                                                       : i_nxt[IDX_W-1:0];
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_word.kind = KIND_DONE;
          emit_word.last = 1'b1;
          st_nxt         = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elap_r <= elap_nxt;
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_r <= mem[rd_addr];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_FULL)
    else $error("entry count above table size");
  assert property (@(posedge clk) disable iff (!rst_n) (st_r == ST_EVAL) |-> (i_r < cnt_r))
    else $error("walker index beyond entry count");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && out_word_r.kind == KIND_FIRED) |-> !out_word_r.last)
    else $error("fired word marked last");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (emit && emit_word.kind == KIND_DONE) |=> (st_r == ST_IDLE))
    else $error("walker not idle after done word");

endmodule

// ===== src/periodic_task_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_task_timer_table: table of one-shot, periodic and time-of-day timers
// Adds entries on command and walks the table on each tick, firing entries.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | word        | words per item
//  ---------+--------------------------------+-------------+-----------------
//  input    | in_valid / in_ready / in_data  | in_word_t   | 1
//  result   | out_valid/ out_ready/ out_data | out_word_t  | 1 per add, N+1 per tick
//
//  Add: an accepted word is registered in the input stage and passes the
//  queue; the table write and the result register then happen together.
//  Tick: the walker visits one table entry per cycle while the result side
//  does not stall it (one read port, read-modify-write per cycle), then
//  emits the done word; it takes no new op until the done word is out.
//  Reset: rst_n synchronous, active low; entry count cleared, no table sweep.
//  Stalls: out_ready low holds the walker on a fired entry or the done word
//  and holds adds; the input stage and two-word queue keep taking words until
//  the queue and the input stage are both full.
//
module periodic_task_timer_table import ptt_pkg::*; #(
  parameter int MAX_TASKS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // front -> queue
  logic f_valid, f_ready;
  op_t  f_op;
  // queue -> back
  logic q_valid, q_ready;
  op_t  q_op;

  ptt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op_data  (f_op)
  );

  ptt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  // table, walker and result register
  ptt_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op_data   (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/ptt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptt_checker: scoreboard for the periodic task timer table
// Keeps a shadow table, predicts the result words of every accepted input
// word and compares each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; #(
  parameter int MAX_TASKS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fails,
  output int        owed_left
);

  // shadow timer table; countdown kept as a plain int
  logic [15:0] slot_handle [MAX_TASKS];
  logic [23:0] slot_period [MAX_TASKS];
  int          slot_countdown [MAX_TASKS];
  int          slot_count;

  out_word_t   owed_words [$];
  int          mismatch_count = 0;

  assign fails = mismatch_count;

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] timer table mismatch: %s", $time, what);
  endtask

  function automatic out_word_t result_word(logic [1:0] kind, logic [15:0] handle,
                                            logic last);
    out_word_t r;
    r.kind         = kind;
    r.fired_handle = handle;
    r.last         = last;
    return r;
  endfunction

  function automatic void file_entry(logic [15:0] handle, logic [23:0] period,
                                     int countdown);
    if (slot_count >= MAX_TASKS) begin
      owed_words.push_back(result_word(KIND_REJECTED, handle, 1'b1));
    end else begin
      slot_handle[slot_count]    = handle;
      slot_period[slot_count]    = period;
      slot_countdown[slot_count] = countdown;
      slot_count++;
      owed_words.push_back(result_word(KIND_ACCEPTED, handle, 1'b1));
    end
  endfunction

  function automatic void run_timer_command(in_word_t w);
    int target;
    int now_s;
    int i;
    int tail;
    case (w.command)
      CMD_ONESHOT:  file_entry(w.task_handle, 24'd0, int'(w.delay_seconds));
      CMD_PERIODIC: file_entry(w.task_handle, w.delay_seconds, int'(w.delay_seconds));
      CMD_TOD: begin
        target = int'(w.target_hour) * int'(SEC_PER_HOUR)
               + int'(w.target_minute) * int'(SEC_PER_MIN) + int'(w.target_second);
        now_s  = int'(w.wall_hour) * int'(SEC_PER_HOUR)
               + int'(w.wall_minute) * int'(SEC_PER_MIN) + int'(w.wall_second);
        // target earlier than now means tomorrow
        if (target < now_s) target += int'(SEC_PER_DAY);
        file_entry(w.task_handle, w.daily ? 24'(SEC_PER_DAY) : 24'd0, target - now_s);
      end
      CMD_TICK: begin
        i = 0;
        while (i < slot_count) begin
          slot_countdown[i] -= int'(w.elapsed_seconds);
          if (slot_countdown[i] <= 0) begin
            owed_words.push_back(result_word(KIND_FIRED, slot_handle[i], 1'b0));
            if (slot_period[i] != 24'd0) begin
              slot_countdown[i] = int'(slot_period[i]);
              i++;
            end else begin
              // one-shot: last entry fills the hole and is looked at next
              tail = slot_count - 1;
              if (i < tail) begin
                slot_handle[i]    = slot_handle[tail];
                slot_period[i]    = slot_period[tail];
                slot_countdown[i] = slot_countdown[tail];
              end
              slot_count = tail;
            end
          end else begin
            i++;
          end
        end
        owed_words.push_back(result_word(KIND_DONE, 16'h0000, 1'b1));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t due;
    if (!rst_n) begin
      slot_count = 0;
      owed_words.delete();
    end else begin
      if (in_valid && in_ready) run_timer_command(in_data);
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d handle %h last %0d",
                                    out_data.kind, out_data.fired_handle, out_data.last));
        end else begin
          due = owed_words.pop_front();
          if (out_data.kind !== due.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", out_data.kind, due.kind));
          if (out_data.fired_handle !== due.fired_handle)
            report_mismatch($sformatf("handle %h, wanted %h",
                                      out_data.fired_handle, due.fired_handle));
          if (out_data.last !== due.last)
            report_mismatch($sformatf("last %0d, wanted %0d", out_data.last, due.last));
        end
      end
    end
    owed_left = owed_words.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the periodic task timer table
// Directed adds and ticks over the corner cases, then random phases that
// alternately fill and drain the table, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import ptt_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int RANDOM_WORDS = 230;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fails;
  int owed_left;
  int cycles = 0;
  int taken = 0;
  bit calm_in = 1'b0;   // no gaps on the input side while set
  bit calm_out = 1'b0;  // no stalls on the result side while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  periodic_task_timer_table #(.MAX_TASKS(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ptt_checker #(.MAX_TASKS(TABLE_DEPTH)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fails     (fails),
    .owed_left (owed_left)
  );

  function automatic int idle_cycles(bit calm);
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Fields a command does not use still get random bits, so every bit of
  // every field toggles over the run.
  function automatic in_word_t timer_word(logic [1:0] cmd, logic [15:0] handle,
                                          logic [23:0] delay, logic [15:0] elapsed);
    in_word_t    w;
    logic [95:0] noise;
    noise             = {$urandom, $urandom, $urandom};
    w                 = noise[$bits(in_word_t)-1:0];
    w.command         = cmd;
    w.task_handle     = handle;
    w.delay_seconds   = delay;
    w.elapsed_seconds = elapsed;
    return w;
  endfunction

  function automatic in_word_t tod_word(logic [15:0] handle,
                                        logic [4:0] th, logic [5:0] tm, logic [5:0] ts,
                                        logic [4:0] nh, logic [5:0] nm, logic [5:0] ns,
                                        logic daily);
    in_word_t w;
    w = timer_word(CMD_TOD, handle, 24'($urandom), 16'($urandom));
    w.target_hour   = th;
    w.target_minute = tm;
    w.target_second = ts;
    w.wall_hour     = nh;
    w.wall_minute   = nm;
    w.wall_second   = ns;
    w.daily         = daily;
    return w;
  endfunction

  // Filling phases are add-heavy so the table reaches full and rejects;
  // draining phases tick more so entries fire and get compacted.
  function automatic in_word_t random_timer_word(bit filling);
    logic [1:0]  cmd;
    logic [23:0] delay;
    logic [15:0] elapsed;
    logic [4:0]  th;
    logic [4:0]  nh;
    logic [5:0]  tm;
    logic [5:0]  ts;
    logic [5:0]  nm;
    logic [5:0]  ns;
    delay   = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
    elapsed = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
    if ($urandom_range(0, 99) < (filling ? 15 : 45))
      return timer_word(CMD_TICK, 16'($urandom), delay, elapsed);
    cmd = 2'($urandom_range(1, 3));
    if (cmd != CMD_TOD)
      return timer_word(cmd, 16'($urandom), delay, elapsed);
    if ($urandom_range(0, 5) == 0) begin
      // whole field widths, hours and minutes past their normal range
      th = 5'($urandom); tm = 6'($urandom); ts = 6'($urandom);
      nh = 5'($urandom); nm = 6'($urandom); ns = 6'($urandom);
    end else begin
      th = 5'($urandom_range(0, 23)); tm = 6'($urandom_range(0, 59));
      ts = 6'($urandom_range(0, 59));
      // same hour half the time keeps countdowns short enough to fire
      nh = $urandom_range(0, 1) ? th : 5'($urandom_range(0, 23));
      nm = 6'($urandom_range(0, 59)); ns = 6'($urandom_range(0, 59));
    end
    return tod_word(16'($urandom), th, tm, ts, nh, nm, ns, 1'($urandom));
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  // Ready is looked at on the falling edge, where it is settled.
  task automatic send_word(in_word_t w);
    int gap;
    gap = idle_cycles(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: a fresh stall is drawn after every word taken.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = idle_cycles(calm_out);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      taken++;
      calm_out = ((taken / 60) % 4) == 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: only the done word
    send_word(timer_word(CMD_TICK, 16'h0000, 24'd0, 16'd0));
    // zero delays; the periodic one has period 0 and acts as one-shot
    send_word(timer_word(CMD_ONESHOT, 16'h0000, 24'd0, 16'hFFFF));
    send_word(timer_word(CMD_PERIODIC, 16'hFFFF, 24'd0, 16'hFFFF));
    // largest delays never expire during the run
    send_word(timer_word(CMD_PERIODIC, 16'h5A5A, 24'hFFFFFF, 16'd0));
    send_word(timer_word(CMD_ONESHOT, 16'hA5A5, 24'hFFFFFF, 16'd0));
    send_word(timer_word(CMD_PERIODIC, 16'h0001, 24'd1, 16'd0));
    // zero elapsed still fires the zero countdowns; removal pulls the
    // last entries down into the freed slots
    send_word(timer_word(CMD_TICK, 16'hFFFF, 24'hFFFFFF, 16'd0));
    // largest elapsed: the period-1 entry fires and reloads
    send_word(timer_word(CMD_TICK, 16'h0000, 24'd0, 16'hFFFF));
    // time of day: wrap past midnight, target equal to now,
    // then out-of-range fields on the target and on the clock
    send_word(tod_word(16'h1111, 5'd1, 6'd0, 6'd0, 5'd23, 6'd0, 6'd0, 1'b1));
    send_word(tod_word(16'h2222, 5'd12, 6'd30, 6'd30, 5'd12, 6'd30, 6'd30, 1'b0));
    send_word(tod_word(16'h3333, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 1'b1));
    // now past a full day: countdown goes negative, fires next tick
    send_word(tod_word(16'h4444, 5'd0, 6'd0, 6'd0, 5'd31, 6'd63, 6'd63, 1'b0));
    send_word(timer_word(CMD_TICK, 16'h1234, 24'd5, 16'd0));
    send_word(timer_word(CMD_TICK, 16'h4321, 24'd5, 16'd1));
    send_word(timer_word(CMD_TICK, 16'h8000, 24'h800000, 16'hFFFF));
    send_word(timer_word(CMD_ONESHOT, 16'hFFFF, 24'h800000, 16'h8000));
    send_word(timer_word(CMD_TICK, 16'h7FFF, 24'h7FFFFF, 16'h8000));

    for (k = 0; k < RANDOM_WORDS; k++) begin
      calm_in = ((k / 25) % 4) == 2;
      send_word(random_timer_word(((k / 40) % 2) == 0));
    end
    in_valid <= 1'b0;

    // wait for every owed word, then watch a while for strays
    do @(negedge clk); while (owed_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
